FILE: src/ikd_pkg.sv
// ----------------------------------------------------------------------------
// ikd_pkg: shared constants and the morse decode table
// Register indexes, keyer mode codes, reset values and the code byte lookup
// used by the iambic keyer with decoder.
// ----------------------------------------------------------------------------
package ikd_pkg;

   // field widths
   localparam int unsigned MODE_W    = 2;
   localparam int unsigned DOT_W     = 8;
   localparam int unsigned TIMER_W   = 10;
   localparam int unsigned COUNT_W   = 4;
   localparam int unsigned BITS_W    = 8;
   localparam int unsigned CHAR_W    = 7;
   localparam int unsigned CSR_IDX_W = 2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_KEYER_MODE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PADDLE_SWAP   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BEATS_PER_DOT = 2'd2;

   // keyer modes
   localparam logic [MODE_W-1:0] MODE_IAMBIC_A    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_IAMBIC_B    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ULTIMATIC   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_DAH_PRIO    = 2'd3;

   // configuration reset values
   localparam logic [MODE_W-1:0] KEYER_MODE_RST    = MODE_IAMBIC_B;
   localparam logic              PADDLE_SWAP_RST   = 1'b0;
   localparam logic [DOT_W-1:0]  BEATS_PER_DOT_RST = 8'd20;

   // paddle latch / symbol codes (bit0 dit, bit1 dah)
   localparam logic [1:0] SYM_NONE = 2'b00;
   localparam logic [1:0] SYM_DIT  = 2'b01;
   localparam logic [1:0] SYM_DAH  = 2'b10;
   localparam logic [1:0] SYM_BOTH = 2'b11;

   // element count limit (only shorter characters decode), and count saturation
   localparam logic [COUNT_W-1:0] MAX_ELEMENTS = 4'd8;
   localparam logic [COUNT_W-1:0] COUNT_MAX    = 4'd15;

   localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;

   // code byte: elements msb first (1 dah, 0 dit), then a stop 1, zero padded
   function automatic logic [CHAR_W-1:0] morse_lookup(input logic [BITS_W-1:0] code);
      logic [CHAR_W-1:0] ch;
      case (code)
         8'hFC: ch = 7'h30; // 0
         8'h7C: ch = 7'h31;
         8'h3C: ch = 7'h32;
         8'h1C: ch = 7'h33;
         8'h0C: ch = 7'h34;
         8'h04: ch = 7'h35;
         8'h84: ch = 7'h36;
         8'hC4: ch = 7'h37;
         8'hE4: ch = 7'h38;
         8'hF4: ch = 7'h39;
         8'h60: ch = 7'h41; // A
         8'h88: ch = 7'h42;
         8'hA8: ch = 7'h43;
         8'h90: ch = 7'h44;
         8'h40: ch = 7'h45;
         8'h28: ch = 7'h46;
         8'hD0: ch = 7'h47;
         8'h08: ch = 7'h48;
         8'h20: ch = 7'h49;
         8'h78: ch = 7'h4A;
         8'hB0: ch = 7'h4B;
         8'h48: ch = 7'h4C;
         8'hE0: ch = 7'h4D;
         8'hA0: ch = 7'h4E;
         8'hF0: ch = 7'h4F;
         8'h68: ch = 7'h50;
         8'hD8: ch = 7'h51;
         8'h50: ch = 7'h52;
         8'h10: ch = 7'h53;
         8'hC0: ch = 7'h54;
         8'h30: ch = 7'h55;
         8'h18: ch = 7'h56;
         8'h70: ch = 7'h57;
         8'h98: ch = 7'h58;
         8'hB8: ch = 7'h59;
         8'hC8: ch = 7'h5A; // Z
         8'h32: ch = 7'h3F; // ?
         8'h8C: ch = 7'h3D; // =
         8'h56: ch = 7'h2E; // .
         8'h16: ch = 7'h23; // #
         8'h54: ch = 7'h24; // $
         8'h94: ch = 7'h2F; // /
         default: ch = CHAR_NONE;
      endcase
      return ch;
   endfunction

endpackage

FILE: src/iambic_keyer_with_decoder.sv
// ----------------------------------------------------------------------------
// iambic_keyer_with_decoder: iambic morse keyer with character decoder
// Paddle keyer (iambic A/B, ultimatic, dah priority) driven by heartbeat
// ticks, with decode of the sent elements into ASCII characters and spaces.
// ----------------------------------------------------------------------------
//
// usage
//   req_ channel: one transaction per heartbeat tick, carrying the dit and dah
//   paddle levels and the word space enable
//   rsp_ channel: exactly one transaction per tick, carrying key_on and the
//   decoded character (0 when none)
//   csr_ channel: register writes (0 keyer_mode, 1 paddle_swap,
//   2 beats_per_dot); always ready, index 3 is ignored; write only while idle
//
// latency and throughput
//   the whole tick update is one pass of logic from the state registers to
//   the result register: the result appears one cycle after acceptance and
//   one tick can be accepted every cycle
//
// reset and stall
//   synchronous reset returns the keyer to idle with empty element buffer and
//   the register reset values (iambic B, no swap, 20 ticks per dot)
//   a skid register behind the result register lets one more tick in while
//   the receiver stalls; req_ready drops only when both hold a result
//
module iambic_keyer_with_decoder (
   input  logic                               clock,
   input  logic                               reset,
   // tick channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_dit_paddle,
   input  logic                               req_dah_paddle,
   input  logic                               req_word_space_enable,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_key_on,
   output logic [ikd_pkg::CHAR_W-1:0]         rsp_char_out,
   // register write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ikd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ikd_pkg::DOT_W-1:0]          csr_data
);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_KEYED = 2'd1,
      ST_GAP   = 2'd2
   } state_type;

   // configuration registers
   logic [ikd_pkg::MODE_W-1:0]  keyer_mode_ff;
   logic                        paddle_swap_ff;
   logic [ikd_pkg::DOT_W-1:0]   beats_per_dot_ff;

   // keyer state
   state_type                   fsm_state_ff,        fsm_state_in;
   logic [ikd_pkg::TIMER_W-1:0] gap_timer_ff,        gap_timer_in;
   logic                        dit_latch_ff,        dit_latch_in;
   logic                        dah_latch_ff,        dah_latch_in;
   logic [1:0]                  last_sent_ff,        last_sent_in;
   logic [ikd_pkg::BITS_W-1:0]  element_bits_ff,     element_bits_in;
   logic [ikd_pkg::COUNT_W-1:0] element_count_ff,    element_count_in;
   logic                        word_gap_pending_ff, word_gap_pending_in;
   logic [1:0]                  ult_memory_ff,       ult_memory_in;

   // result register and skid register
   logic                        rsp_valid_ff,  rsp_valid_in;
   logic                        rsp_key_ff,    rsp_key_in;
   logic [ikd_pkg::CHAR_W-1:0]  rsp_char_ff,   rsp_char_in;
   logic                        skid_valid_ff, skid_valid_in;
   logic                        skid_key_ff,   skid_key_in;
   logic [ikd_pkg::CHAR_W-1:0]  skid_char_ff,  skid_char_in;

   logic                        req_accept;
   logic                        rsp_pop;
   logic                        csr_accept;

   // combinational tick result
   logic                        key_next;
   logic [ikd_pkg::CHAR_W-1:0]  char_next;

   // scratch for the tick update
   logic                        dit_eff, dah_eff;
   logic [1:0]                  lat;
   logic [ikd_pkg::TIMER_W-1:0] dot_ext;
   logic [ikd_pkg::TIMER_W-1:0] timer_dec;
   logic [ikd_pkg::BITS_W-1:0]  code_byte;
   logic [2:0]                  pad_shift;

   // -------------------------------------------------------------------------
   // handshakes
   // -------------------------------------------------------------------------
   assign req_ready  = !skid_valid_ff;
   assign req_accept = req_valid && req_ready;
   assign rsp_pop    = rsp_valid_ff && rsp_ready;
   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_key_on   = rsp_key_ff;
   assign rsp_char_out = rsp_char_ff;

   // swap exchanges paddle roles before latching
   assign dit_eff = paddle_swap_ff ? req_dah_paddle : req_dit_paddle;
   assign dah_eff = paddle_swap_ff ? req_dit_paddle : req_dah_paddle;
   assign dot_ext = {{(ikd_pkg::TIMER_W - ikd_pkg::DOT_W){1'b0}}, beats_per_dot_ff};

   // -------------------------------------------------------------------------
   // tick update: timer countdown, latch sampling, element start, decode
   // -------------------------------------------------------------------------
   always_comb begin
      fsm_state_in        = fsm_state_ff;
      dit_latch_in        = dit_latch_ff;
      dah_latch_in        = dah_latch_ff;
      last_sent_in        = last_sent_ff;
      element_bits_in     = element_bits_ff;
      element_count_in    = element_count_ff;
      ult_memory_in       = ult_memory_ff;
      char_next           = ikd_pkg::CHAR_NONE;
      lat                 = ikd_pkg::SYM_NONE;
      code_byte           = '0;
      pad_shift           = '0;

      timer_dec    = (gap_timer_ff != '0) ? gap_timer_ff - 1'b1 : gap_timer_ff;
      gap_timer_in = timer_dec;

      word_gap_pending_in = word_gap_pending_ff && req_word_space_enable;

      case (fsm_state_ff)
         ST_KEYED: begin
            // only iambic B remembers paddles pressed during the element
            if (keyer_mode_ff == ikd_pkg::MODE_IAMBIC_B) begin
               dit_latch_in = dit_latch_ff | dit_eff;
               dah_latch_in = dah_latch_ff | dah_eff;
            end
            if (timer_dec == '0) begin
               gap_timer_in = dot_ext;
               fsm_state_in = ST_GAP;
            end
         end
         ST_GAP: begin
            dit_latch_in = dit_latch_ff | dit_eff;
            dah_latch_in = dah_latch_ff | dah_eff;
            if (timer_dec == '0) begin
               fsm_state_in = ST_IDLE;
               gap_timer_in = dot_ext;
            end
         end
         default: begin
            // idle, and the unreachable code behaves the same
            fsm_state_in = ST_IDLE;
            lat = {dah_latch_ff | dah_eff, dit_latch_ff | dit_eff};
            case (keyer_mode_ff)
               ikd_pkg::MODE_IAMBIC_A,
               ikd_pkg::MODE_IAMBIC_B: begin
                  // alternate: drop the symbol just sent
                  lat          = lat & ~last_sent_ff;
                  last_sent_in = ikd_pkg::SYM_NONE;
               end
               ikd_pkg::MODE_ULTIMATIC: begin
                  if (lat == ikd_pkg::SYM_BOTH) begin
                     if (ult_memory_ff != ikd_pkg::SYM_NONE) begin
                        lat = lat & ~ult_memory_ff;
                     end else begin
                        lat = ikd_pkg::SYM_DAH;
                     end
                  end else begin
                     ult_memory_in = lat;
                  end
               end
               default: begin
                  // dah priority
                  if (lat == ikd_pkg::SYM_BOTH) begin
                     lat = ikd_pkg::SYM_DAH;
                  end
               end
            endcase
            dit_latch_in = lat[0];
            dah_latch_in = lat[1];

            if (timer_dec == '0 && element_count_ff != '0) begin
               // character gap: decode the collected elements
               if (element_count_ff < ikd_pkg::MAX_ELEMENTS) begin
                  pad_shift = 3'd7 - element_count_ff[2:0];
                  code_byte = {element_bits_ff[ikd_pkg::BITS_W-2:0], 1'b1} << pad_shift;
                  char_next = ikd_pkg::morse_lookup(code_byte);
               end
               element_bits_in     = '0;
               element_count_in    = '0;
               gap_timer_in        = {dot_ext[ikd_pkg::TIMER_W-3:0], 2'b00};
               word_gap_pending_in = 1'b1;
            end else if (timer_dec == '0 && word_gap_pending_in) begin
               word_gap_pending_in = 1'b0;
               char_next           = ikd_pkg::CHAR_SPACE;
            end else if (lat != ikd_pkg::SYM_NONE) begin
               // start an element
               word_gap_pending_in = 1'b0;
               if (element_count_ff < ikd_pkg::COUNT_MAX) begin
                  element_count_in = element_count_ff + 1'b1;
               end
               if (lat[0]) begin
                  gap_timer_in    = dot_ext;
                  last_sent_in    = ikd_pkg::SYM_DIT;
                  element_bits_in = {element_bits_ff[ikd_pkg::BITS_W-2:0], 1'b0};
               end else begin
                  gap_timer_in    = {dot_ext[ikd_pkg::TIMER_W-2:0], 1'b0} + dot_ext;
                  last_sent_in    = ikd_pkg::SYM_DAH;
                  element_bits_in = {element_bits_ff[ikd_pkg::BITS_W-2:0], 1'b1};
               end
               dit_latch_in = 1'b0;
               dah_latch_in = 1'b0;
               fsm_state_in = ST_KEYED;
            end
         end
      endcase

      key_next = (fsm_state_in == ST_KEYED);
   end

   // -------------------------------------------------------------------------
   // result register with skid stage
   // -------------------------------------------------------------------------
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_char_in   = rsp_char_ff;
      skid_valid_in = skid_valid_ff;
      skid_key_in   = skid_key_ff;
      skid_char_in  = skid_char_ff;
      if (skid_valid_ff) begin
         // no new transaction can arrive while the skid stage is full
         if (rsp_pop) begin
            rsp_key_in    = skid_key_ff;
            rsp_char_in   = skid_char_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_accept) begin
         if (!rsp_valid_ff || rsp_pop) begin
            rsp_valid_in = 1'b1;
            rsp_key_in   = key_next;
            rsp_char_in  = char_next;
         end else begin
            skid_valid_in = 1'b1;
            skid_key_in   = key_next;
            skid_char_in  = char_next;
         end
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   // -------------------------------------------------------------------------
   // registers
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      // payload registers, no reset
      rsp_key_ff   <= rsp_key_in;
      rsp_char_ff  <= rsp_char_in;
      skid_key_ff  <= skid_key_in;
      skid_char_ff <= skid_char_in;
      if (reset) begin
         keyer_mode_ff       <= ikd_pkg::KEYER_MODE_RST;
         paddle_swap_ff      <= ikd_pkg::PADDLE_SWAP_RST;
         beats_per_dot_ff    <= ikd_pkg::BEATS_PER_DOT_RST;
         fsm_state_ff        <= ST_IDLE;
         gap_timer_ff        <= '0;
         dit_latch_ff        <= 1'b0;
         dah_latch_ff        <= 1'b0;
         last_sent_ff        <= ikd_pkg::SYM_NONE;
         element_bits_ff     <= '0;
         element_count_ff    <= '0;
         word_gap_pending_ff <= 1'b0;
         ult_memory_ff       <= ikd_pkg::SYM_NONE;
         rsp_valid_ff        <= 1'b0;
         skid_valid_ff       <= 1'b0;
      end else begin
         if (csr_accept) begin
            case (csr_index)
               ikd_pkg::CSR_KEYER_MODE:    keyer_mode_ff    <= csr_data[ikd_pkg::MODE_W-1:0];
               ikd_pkg::CSR_PADDLE_SWAP:   paddle_swap_ff   <= csr_data[0];
               ikd_pkg::CSR_BEATS_PER_DOT: beats_per_dot_ff <= csr_data;
               default: ;
            endcase
         end
         if (req_accept) begin
            fsm_state_ff        <= fsm_state_in;
            gap_timer_ff        <= gap_timer_in;
            dit_latch_ff        <= dit_latch_in;
            dah_latch_ff        <= dah_latch_in;
            last_sent_ff        <= last_sent_in;
            element_bits_ff     <= element_bits_in;
            element_count_ff    <= element_count_in;
            word_gap_pending_ff <= word_gap_pending_in;
            ult_memory_ff       <= ult_memory_in;
         end
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // -------------------------------------------------------------------------
   // assertions
   // -------------------------------------------------------------------------
   // skid stage only fills behind a held result
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register full while result register empty");

   // keyer state moves only on an accepted tick
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(fsm_state_ff) && $stable(gap_timer_ff))
      else $error("keyer state changed without a tick");

   // a character or space is only reported on a tick that starts no element
   a_char_not_keyed: assert property (@(posedge clock) disable iff (reset)
      req_accept && (char_next != ikd_pkg::CHAR_NONE) |-> !key_next)
      else $error("character reported together with a new element");

   // empty element buffer carries no element bits
   a_empty_buffer: assert property (@(posedge clock) disable iff (reset)
      (element_count_ff == '0) |-> (element_bits_ff == '0))
      else $error("element bits left with zero element count");

   // an accepted tick leaves the result register holding a result
   a_result_taken: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted tick produced no result");

endmodule
